// ===== rtl/hidrb_pkg.sv =====
// hidrb_pkg: shared types and constants of the hid input report builder
// operation codes, result kinds, report ids and the command passed front to back
// no dependencies
package hidrb_pkg;

  typedef enum logic [3:0] {
    OP_KB_PRESS       = 4'd0,
    OP_KB_RELEASE     = 4'd1,
    OP_KB_RELEASE_ALL = 4'd2,
    OP_MOVE           = 4'd3,
    OP_M_PRESS        = 4'd4,
    OP_M_RELEASE      = 4'd5,
    OP_SCROLL         = 4'd6,
    OP_C_PRESS        = 4'd7,
    OP_C_RELEASE      = 4'd8,
    OP_WAKEUP         = 4'd9,
    OP_SUSPEND        = 4'd10
  } op_t;

  // event class decided by the front end
  typedef enum logic [2:0] {
    CLS_KEYBOARD,
    CLS_MOUSE,
    CLS_CONSUMER,
    CLS_LINK,
    CLS_OTHER
  } cls_t;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_REFUSED = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  localparam logic [7:0] ID_KEYBOARD = 8'd1;
  localparam logic [7:0] ID_MOUSE    = 8'd2;
  localparam logic [7:0] ID_CONSUMER = 8'd3;

  localparam int MOUSE_LEN = 5;

  typedef struct packed {
    cls_t        cls;
    op_t         op;
    logic [15:0] key_code;
    logic [7:0]  mouse_button_mask;
    logic [7:0]  delta_x;
    logic [7:0]  delta_y;
    logic [7:0]  wheel_delta;
  } cmd_t;

endpackage

// ===== rtl/hidrb_front.sv =====
// hidrb_front: input register that accepts events and classifies them
// produces hidrb_pkg::cmd_t for the command queue
// depends on hidrb_pkg
module hidrb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_op,
  input  logic [47:0]        in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output hidrb_pkg::cmd_t    cmd
);

  hidrb_pkg::cls_t cls_next;
  hidrb_pkg::op_t  op_in;

  assign op_in    = hidrb_pkg::op_t'(in_op);
  assign in_ready = !cmd_valid || cmd_ready;

  always_comb begin
    case (op_in)
      hidrb_pkg::OP_KB_PRESS, hidrb_pkg::OP_KB_RELEASE,
      hidrb_pkg::OP_KB_RELEASE_ALL:                      cls_next = hidrb_pkg::CLS_KEYBOARD;
      hidrb_pkg::OP_MOVE, hidrb_pkg::OP_M_PRESS,
      hidrb_pkg::OP_M_RELEASE, hidrb_pkg::OP_SCROLL:     cls_next = hidrb_pkg::CLS_MOUSE;
      hidrb_pkg::OP_C_PRESS, hidrb_pkg::OP_C_RELEASE:    cls_next = hidrb_pkg::CLS_CONSUMER;
      hidrb_pkg::OP_WAKEUP, hidrb_pkg::OP_SUSPEND:       cls_next = hidrb_pkg::CLS_LINK;
      default:                                           cls_next = hidrb_pkg::CLS_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd.cls               <= cls_next;
      cmd.op                <= op_in;
      cmd.key_code          <= in_data[15:0];
      cmd.mouse_button_mask <= in_data[23:16];
      cmd.delta_x           <= in_data[31:24];
      cmd.delta_y           <= in_data[39:32];
      cmd.wheel_delta       <= in_data[47:40];
    end
  end

endmodule

// ===== rtl/hidrb_queue.sv =====
// hidrb_queue: two-entry command queue between front and back
// decouples event intake from report emission
// depends on hidrb_pkg
module hidrb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  hidrb_pkg::cmd_t wr_cmd,
  output logic            rd_valid,
  input  logic            rd_pop,
  output hidrb_pkg::cmd_t rd_cmd
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hidrb_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// ===== rtl/hidrb_back.sv =====
// hidrb_back: report state, event execution and byte-serial report output
// takes commands from hidrb_queue, drives the result stream register
// depends on hidrb_pkg
module hidrb_back #(
  parameter int KEY_SLOTS      = 6,
  parameter int CONSUMER_SLOTS = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_pop,
  input  hidrb_pkg::cmd_t q_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_link_up
);

  localparam int KB_LEN  = 3 + KEY_SLOTS;
  localparam int CC_LEN  = 1 + 2 * CONSUMER_SLOTS;
  localparam int LEN_A   = (KB_LEN > hidrb_pkg::MOUSE_LEN) ? KB_LEN : hidrb_pkg::MOUSE_LEN;
  localparam int LEN_MAX = (LEN_A > CC_LEN) ? LEN_A : CC_LEN;
  localparam int IDX_W   = $clog2(LEN_MAX);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] last_idx_next;
  logic [1:0]       res_kind;
  logic [1:0]       res_kind_next;
  hidrb_pkg::cls_t  rep_cls;
  logic [7:0]       rep_dx;
  logic [7:0]       rep_dy;
  logic [7:0]       rep_wh;

  logic [7:0]  key_slots [KEY_SLOTS];
  logic [7:0]  key_slots_next [KEY_SLOTS];
  logic [7:0]  modifier_bits;
  logic [7:0]  modifier_bits_next;
  logic [7:0]  mouse_buttons_held;
  logic [7:0]  mouse_buttons_held_next;
  logic [15:0] consumer_slots [CONSUMER_SLOTS];
  logic [15:0] consumer_slots_next [CONSUMER_SLOTS];
  logic        connected;
  logic        connected_next;

  logic [7:0]  key;
  logic [7:0]  mods;
  logic        hit;
  logic        out_free;
  logic [7:0]  byte_sel;

  assign key      = q_cmd.key_code[7:0];
  assign mods     = q_cmd.key_code[15:8];
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;

  // state update for the command at the head of the queue
  always_comb begin
    key_slots_next          = key_slots;
    consumer_slots_next     = consumer_slots;
    modifier_bits_next      = modifier_bits;
    mouse_buttons_held_next = mouse_buttons_held;
    connected_next          = connected;
    hit                     = 1'b0;
    case (q_cmd.op)
      hidrb_pkg::OP_KB_PRESS: begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (!hit && key_slots[i] == 8'h00) begin
            key_slots_next[i] = key;
            hit               = 1'b1;
          end
        end
        modifier_bits_next = modifier_bits | mods;
      end
      hidrb_pkg::OP_KB_RELEASE: begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (!hit && key_slots[i] == key) begin
            key_slots_next[i] = 8'h00;
            hit               = 1'b1;
          end
        end
        modifier_bits_next = modifier_bits & ~mods;
      end
      hidrb_pkg::OP_KB_RELEASE_ALL: begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          key_slots_next[i] = 8'h00;
        end
        modifier_bits_next = 8'h00;
      end
      hidrb_pkg::OP_M_PRESS: begin
        mouse_buttons_held_next = mouse_buttons_held | q_cmd.mouse_button_mask;
      end
      hidrb_pkg::OP_M_RELEASE: begin
        mouse_buttons_held_next = mouse_buttons_held & ~q_cmd.mouse_button_mask;
      end
      hidrb_pkg::OP_C_PRESS: begin
        for (int i = 0; i < CONSUMER_SLOTS; i++) begin
          if (!hit && consumer_slots[i] == 16'h0000) begin
            consumer_slots_next[i] = q_cmd.key_code;
            hit                    = 1'b1;
          end
        end
      end
      hidrb_pkg::OP_C_RELEASE: begin
        for (int i = 0; i < CONSUMER_SLOTS; i++) begin
          if (!hit && consumer_slots[i] == q_cmd.key_code) begin
            consumer_slots_next[i] = 16'h0000;
            hit                    = 1'b1;
          end
        end
      end
      hidrb_pkg::OP_WAKEUP:  connected_next = 1'b1;
      hidrb_pkg::OP_SUSPEND: connected_next = 1'b0;
      default: ;
    endcase
  end

  // result shape: a full report, or a single refusal or acknowledge
  always_comb begin
    res_kind_next = hidrb_pkg::KIND_BYTE;
    last_idx_next = '0;
    case (q_cmd.cls)
      hidrb_pkg::CLS_KEYBOARD: last_idx_next = IDX_W'(KB_LEN - 1);
      hidrb_pkg::CLS_MOUSE:    last_idx_next = IDX_W'(hidrb_pkg::MOUSE_LEN - 1);
      hidrb_pkg::CLS_CONSUMER: last_idx_next = IDX_W'(CC_LEN - 1);
      default:                 res_kind_next = hidrb_pkg::KIND_ACK;
    endcase
    if (res_kind_next == hidrb_pkg::KIND_BYTE && !connected) begin
      res_kind_next = hidrb_pkg::KIND_REFUSED;
      last_idx_next = '0;
    end
  end

  // report byte at the current position
  always_comb begin
    byte_sel = 8'h00;
    case (rep_cls)
      hidrb_pkg::CLS_KEYBOARD: begin
        if (idx == '0) begin
          byte_sel = hidrb_pkg::ID_KEYBOARD;
        end else if (idx == IDX_W'(1)) begin
          byte_sel = modifier_bits;
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (idx == IDX_W'(3 + i)) begin
            byte_sel = key_slots[i];
          end
        end
      end
      hidrb_pkg::CLS_MOUSE: begin
        if (idx == '0) begin
          byte_sel = hidrb_pkg::ID_MOUSE;
        end else if (idx == IDX_W'(1)) begin
          byte_sel = mouse_buttons_held;
        end else if (idx == IDX_W'(2)) begin
          byte_sel = rep_dx;
        end else if (idx == IDX_W'(3)) begin
          byte_sel = rep_dy;
        end else if (idx == IDX_W'(4)) begin
          byte_sel = rep_wh;
        end
      end
      hidrb_pkg::CLS_CONSUMER: begin
        if (idx == '0) begin
          byte_sel = hidrb_pkg::ID_CONSUMER;
        end
        for (int i = 0; i < CONSUMER_SLOTS; i++) begin
          if (idx == IDX_W'(1 + 2 * i)) begin
            byte_sel = consumer_slots[i][7:0];
          end else if (idx == IDX_W'(2 + 2 * i)) begin
            byte_sel = consumer_slots[i][15:8];
          end
        end
      end
      default: byte_sel = 8'h00;
    endcase
    if (res_kind != hidrb_pkg::KIND_BYTE) begin
      byte_sel = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      out_valid          <= 1'b0;
      out_kind           <= hidrb_pkg::KIND_BYTE;
      out_byte           <= 8'h00;
      out_last           <= 1'b0;
      out_link_up        <= 1'b0;
      modifier_bits      <= 8'h00;
      mouse_buttons_held <= 8'h00;
      connected          <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        key_slots[i] <= 8'h00;
      end
      for (int i = 0; i < CONSUMER_SLOTS; i++) begin
        consumer_slots[i] <= 16'h0000;
      end
    end else begin
      // output register loads a new result or empties after its transfer
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            key_slots          <= key_slots_next;
            consumer_slots     <= consumer_slots_next;
            modifier_bits      <= modifier_bits_next;
            mouse_buttons_held <= mouse_buttons_held_next;
            connected          <= connected_next;
            state              <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_kind    <= res_kind;
            out_byte    <= byte_sel;
            out_last    <= (idx == last_idx);
            out_link_up <= connected;
            if (idx == last_idx) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      idx      <= '0;
      last_idx <= last_idx_next;
      res_kind <= res_kind_next;
      rep_cls  <= q_cmd.cls;
      rep_dx   <= (q_cmd.op == hidrb_pkg::OP_MOVE) ? q_cmd.delta_x : 8'h00;
      rep_dy   <= (q_cmd.op == hidrb_pkg::OP_MOVE) ? q_cmd.delta_y : 8'h00;
      rep_wh   <= (q_cmd.op == hidrb_pkg::OP_SCROLL) ? q_cmd.wheel_delta : 8'h00;
    end else if (state == ST_EMIT && out_free) begin
      idx <= idx + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_byte_needs_link: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == hidrb_pkg::KIND_BYTE) |-> out_link_up)
    else $error("report byte sent while disconnected");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != hidrb_pkg::KIND_BYTE) |-> (out_last && out_byte == 8'h00))
    else $error("refusal or acknowledge not a single zero result");

  a_pop_starts_emit: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_EMIT && idx == '0))
    else $error("command pop did not start emission");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !q_pop)
    else $error("queue popped during emission");
`endif

endmodule

// ===== rtl/hid_input_report_builder.sv =====
// hid_input_report_builder: top level over hidrb_front, hidrb_queue, hidrb_back and hidrb_pkg
// an input transfer passes the intake register, the queue and the back-end pop on its way to
// the output register; then one result per cycle while the receiver is ready
// results per event: 3 + KEY_SLOTS (keyboard), 5 (mouse), 1 + 2*CONSUMER_SLOTS (consumer),
// 1 (refusal or acknowledge); the back end pops the next event only after the last result
// reset: synchronous active-high rst clears report state and valid flags, drops the link
module hid_input_report_builder #(
  parameter int KEY_SLOTS      = 6,
  parameter int CONSUMER_SLOTS = 2
) (
  input  logic        clk,
  input  logic        rst,
  // event input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // key_code[15:0], mouse_button_mask[23:16],
                                      // delta_x[31:24], delta_y[39:32], wheel_delta[47:40]
  input  logic [3:0]  s_axis_tuser,   // operation[3:0]
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // report_byte[7:0], link_up[8], zero[15:9]
  output logic [1:0]  m_axis_tuser,   // result_kind[1:0]
  output logic        m_axis_tlast    // last result of the event
);

  // front to queue
  logic            f_valid;
  logic            f_ready;
  hidrb_pkg::cmd_t f_cmd;

  // queue to back
  logic            q_valid;
  logic            q_pop;
  hidrb_pkg::cmd_t q_cmd;

  logic [7:0]      out_byte;
  logic            out_link_up;

  // intake register and event classification
  hidrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // short command queue so intake keeps going while a report drains
  hidrb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_cmd   (q_cmd)
  );

  // state update and byte-serial report emission
  hidrb_back #(
    .KEY_SLOTS      (KEY_SLOTS),
    .CONSUMER_SLOTS (CONSUMER_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_cmd       (q_cmd),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (m_axis_tuser),
    .out_byte    (out_byte),
    .out_last    (m_axis_tlast),
    .out_link_up (out_link_up)
  );

  assign m_axis_tdata = {7'b0, out_link_up, out_byte};

endmodule
